>>> src/bfr_pkg.sv
// Package for the binary frame receiver: phase and status codes, register
// addresses, reset values and the structs passed between the submodules.
// Depends on nothing; every other file of the block but the two interfaces imports it.
`default_nettype none

package bfr_pkg;

  // Start pair and checksum width.
  localparam logic [7:0] SYNC_FIRST  = 8'hA0;
  localparam logic [7:0] SYNC_SECOND = 8'hA2;
  localparam int unsigned SUM_W      = 15;

  // Input operation codes.
  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_TIMEOUT = 1'b1;

  // Result kinds.
  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Configuration port layout: one 32-bit register every four bytes.
  localparam int unsigned CFG_ADDR_W  = 3;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam logic [CFG_ADDR_W-1:0] ADDR_PATIENCE = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] ADDR_MAX_LEN  = 3'd4;

  // Register reset values.
  localparam logic [15:0] PATIENCE_RESET = 16'd1024;
  localparam logic [15:0] MAX_LEN_RESET  = 16'd2044;

  // Receive phases.
  typedef enum logic [2:0] {
    PH_WAIT_A0 = 3'd0,
    PH_WAIT_A2 = 3'd1,
    PH_LEN_HI  = 3'd2,
    PH_LEN_LO  = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CK_HI   = 3'd5,
    PH_CK_LO   = 3'd6
  } phase_t;

  // End-of-frame status codes.
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_CHECKSUM    = 3'd1,
    ST_TRUNCATED   = 3'd2,
    ST_BAD_LENGTH  = 3'd3,
    ST_LEN_MISSING = 3'd4,
    ST_NO_SYNC     = 3'd5
  } status_t;

  // Configuration values seen by the deframer.
  typedef struct packed {
    logic [15:0] patience_limit;
    logic [15:0] max_length;
  } cfg_t;

  // One result item together with its valid flag.
  typedef struct packed {
    logic        valid;
    logic        kind;
    logic [7:0]  payload_byte;
    status_t     status;
  } res_t;

endpackage

`default_nettype wire

>>> src/bfr_in_if.sv
// Input channel of the frame receiver: one received byte or timeout per transfer.
// Stand-alone interface; no package needed.
`default_nettype none

interface bfr_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] rx_byte;

  modport source (output valid, output op, output rx_byte, input ready);
  modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

`default_nettype wire

>>> src/bfr_out_if.sv
// Result channel of the frame receiver: a payload byte or an end-of-frame status.
// Stand-alone interface; no package needed.
`default_nettype none

interface bfr_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] payload_byte;
  logic [2:0] status;

  modport source (output valid, output kind, output payload_byte, output status,
                  input ready);
  modport sink   (input valid, input kind, input payload_byte, input status,
                  output ready);
endinterface

`default_nettype wire

>>> src/bfr_cfg.sv
// APB-style register file of the frame receiver: patience limit and maximum length.
// Depends on bfr_pkg for addresses, reset values and the cfg_t struct.
`default_nettype none

module bfr_cfg
  import bfr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output cfg_t                       cfg
);

  logic [15:0] patience_r;
  logic [15:0] max_len_r;
  logic        wr_en;

  // A write completes in the access cycle; pready is tied high at the top.
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      patience_r <= PATIENCE_RESET;
      max_len_r  <= MAX_LEN_RESET;
    end else if (wr_en) begin
      if (paddr == ADDR_PATIENCE) begin
        patience_r <= pwdata[15:0];
      end
      if (paddr == ADDR_MAX_LEN) begin
        max_len_r <= pwdata[15:0];
      end
    end
  end

  // Read back; unmapped addresses read as zero.
  always_comb begin
    prdata = '0;
    if (paddr == ADDR_PATIENCE) begin
      prdata = {{(CFG_DATA_W-16){1'b0}}, patience_r};
    end else if (paddr == ADDR_MAX_LEN) begin
      prdata = {{(CFG_DATA_W-16){1'b0}}, max_len_r};
    end
  end

  assign cfg.patience_limit = patience_r;
  assign cfg.max_length     = max_len_r;

endmodule

`default_nettype wire

>>> src/bfr_fsm.sv
// Deframer state machine: sync hunt, length, payload with running sum, checksum.
// Depends on bfr_pkg for the phase and status enums and the cfg_t/res_t structs.
`default_nettype none

module bfr_fsm
  import bfr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic       op,
  input  wire logic [7:0] rx_byte,
  input  wire cfg_t       cfg,
  output res_t            res,
  output phase_t          phase
);

  phase_t           phase_r,    phase_nxt;
  logic [15:0]      patience_r, patience_nxt;
  logic [15:0]      length_r,   length_nxt;
  logic [15:0]      count_r,    count_nxt;
  logic [SUM_W-1:0] sum_r,      sum_nxt;
  logic [7:0]       held_r,     held_nxt;

  logic        timeout;
  logic        exhausted;
  logic [15:0] rx_word;
  logic [15:0] count_inc;
  logic        end_frame;
  status_t     end_code;
  logic        emit_byte;
  logic        charge;
  logic        restart;

  assign timeout   = (op == OP_TIMEOUT);
  assign exhausted = (patience_r <= 16'd1);
  assign rx_word   = {held_r, rx_byte};
  assign count_inc = count_r + 16'd1;

  // Next phase and the decisions that drive the datapath and the result.
  always_comb begin
    phase_nxt = phase_r;
    end_frame = 1'b0;
    end_code  = ST_OK;
    emit_byte = 1'b0;
    charge    = 1'b0;
    restart   = 1'b0;
    if (accept) begin
      unique case (phase_r)
        PH_WAIT_A0: begin
          if (timeout) begin
            charge = 1'b1;
          end else if (rx_byte == SYNC_FIRST) begin
            phase_nxt = PH_WAIT_A2;
          end else if (rx_byte != SYNC_SECOND) begin
            charge = 1'b1;
          end
          if (charge && exhausted) begin
            end_frame = 1'b1;
            end_code  = ST_NO_SYNC;
          end
        end
        PH_WAIT_A2: begin
          if (timeout) begin
            charge = 1'b1;
          end else if (rx_byte == SYNC_SECOND) begin
            phase_nxt = PH_LEN_HI;
          end else if (rx_byte != SYNC_FIRST) begin
            phase_nxt = PH_WAIT_A0;
            charge    = 1'b1;
          end
          if (charge && exhausted) begin
            end_frame = 1'b1;
            end_code  = ST_NO_SYNC;
          end
        end
        PH_LEN_HI: begin
          if (timeout) begin
            end_frame = 1'b1;
            end_code  = ST_LEN_MISSING;
          end else begin
            phase_nxt = PH_LEN_LO;
          end
        end
        PH_LEN_LO: begin
          if (timeout) begin
            end_frame = 1'b1;
            end_code  = ST_LEN_MISSING;
          end else if (rx_word == 16'd0 || rx_word > cfg.max_length) begin
            end_frame = 1'b1;
            end_code  = ST_BAD_LENGTH;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          if (timeout) begin
            end_frame = 1'b1;
            end_code  = ST_TRUNCATED;
          end else begin
            emit_byte = 1'b1;
            if (count_inc >= length_r) begin
              phase_nxt = PH_CK_HI;
            end
          end
        end
        PH_CK_HI: begin
          if (timeout) begin
            end_frame = 1'b1;
            end_code  = ST_TRUNCATED;
          end else begin
            phase_nxt = PH_CK_LO;
          end
        end
        PH_CK_LO: begin
          end_frame = 1'b1;
          if (timeout) begin
            end_code = ST_TRUNCATED;
          end else if (rx_word == {1'b0, sum_r}) begin
            end_code = ST_OK;
          end else begin
            end_code = ST_CHECKSUM;
          end
        end
        default: begin
          restart = 1'b1;
        end
      endcase
    end
    if (end_frame || restart) begin
      phase_nxt = PH_WAIT_A0;
    end
  end

  // Counters, sum and held byte; a new attempt reloads patience and clears the rest.
  always_comb begin
    patience_nxt = patience_r;
    length_nxt   = length_r;
    count_nxt    = count_r;
    sum_nxt      = sum_r;
    held_nxt     = held_r;
    if (end_frame || restart) begin
      patience_nxt = cfg.patience_limit;
      length_nxt   = '0;
      count_nxt    = '0;
      sum_nxt      = '0;
      held_nxt     = '0;
    end else if (accept) begin
      if (charge) begin
        patience_nxt = patience_r - 16'd1;
      end
      if (!timeout && (phase_r == PH_LEN_HI || phase_r == PH_CK_HI)) begin
        held_nxt = rx_byte;
      end
      if (phase_r == PH_LEN_LO) begin
        length_nxt = rx_word;
        count_nxt  = '0;
        sum_nxt    = '0;
      end
      if (emit_byte) begin
        count_nxt = count_inc;
        sum_nxt   = sum_r + {{(SUM_W-8){1'b0}}, rx_byte};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_WAIT_A0;
      patience_r <= PATIENCE_RESET;
      length_r   <= '0;
      count_r    <= '0;
      sum_r      <= '0;
      held_r     <= '0;
    end else begin
      phase_r    <= phase_nxt;
      patience_r <= patience_nxt;
      length_r   <= length_nxt;
      count_r    <= count_nxt;
      sum_r      <= sum_nxt;
      held_r     <= held_nxt;
    end
  end

  // Result of this transfer, if any.
  always_comb begin
    res.valid        = end_frame || emit_byte;
    res.kind         = end_frame ? KIND_STATUS : KIND_BYTE;
    res.payload_byte = emit_byte ? rx_byte : 8'd0;
    res.status       = end_frame ? end_code : ST_OK;
  end

  assign phase = phase_r;

endmodule

`default_nettype wire

>>> src/bfr_out_buf.sv
// Result register with one skid entry, so input ready never waits on output ready.
// Depends on bfr_pkg for the res_t struct.
`default_nettype none

module bfr_out_buf
  import bfr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire res_t res,
  input  wire logic out_ready,
  output logic      out_valid,
  output res_t      out_data,
  output logic      in_ready
);

  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  res_t out_r;
  res_t skid_r;
  logic pop;
  logic load_out;
  logic load_skid;

  // A result only arrives while the skid entry is free, because ready is low otherwise.
  assign pop = out_valid_r && out_ready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    load_out       = 1'b0;
    load_skid      = 1'b0;
    if (skid_valid_r) begin
      if (pop) begin
        skid_valid_nxt = 1'b0;
      end
    end else if (res.valid) begin
      if (!out_valid_r || pop) begin
        load_out      = 1'b1;
        out_valid_nxt = 1'b1;
      end else begin
        load_skid      = 1'b1;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Payload registers; the skid entry moves forward when the output is taken.
  always_ff @(posedge clk) begin
    if (skid_valid_r && pop) begin
      out_r <= skid_r;
    end else if (load_out) begin
      out_r <= res;
    end
    if (load_skid) begin
      skid_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign in_ready  = !skid_valid_r;

endmodule

`default_nettype wire

>>> src/binary_frame_receiver.sv
// Binary frame receiver. Takes one received byte or read timeout per input
// transfer, hunts for the start pair A0 A2, reads a big-endian 16-bit length,
// forwards each payload byte as a result while keeping a 15-bit running sum,
// and ends every frame attempt with one status result (ok, checksum mismatch,
// truncated, bad length, length missing, no sync). Each input transfer is
// handled in the cycle it is accepted, so a new byte can be taken every
// cycle; the result register plus one skid entry keep input ready high
// while one result waits behind a stalled output, and input ready drops only while
// both hold an untaken result. Registers: patience limit at 0x0, maximum
// length at 0x4; write them only while no frame is in progress.
`default_nettype none

module binary_frame_receiver
  import bfr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  bfr_in_if.sink                     in_bus,
  bfr_out_if.source                  out_bus,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  cfg_t   cfg;
  res_t   res;
  res_t   out_data;
  phase_t phase;
  logic   in_ready;
  logic   accept;

  assign pready = 1'b1;
  assign accept = in_bus.valid && in_ready;
  assign in_bus.ready = in_ready;

  // Configuration registers.
  bfr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // Frame state machine.
  bfr_fsm u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .op      (in_bus.op),
    .rx_byte (in_bus.rx_byte),
    .cfg     (cfg),
    .res     (res),
    .phase   (phase)
  );

  // Result register and skid entry.
  bfr_out_buf u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .out_ready (out_bus.ready),
    .out_valid (out_bus.valid),
    .out_data  (out_data),
    .in_ready  (in_ready)
  );

  assign out_bus.kind         = out_data.kind;
  assign out_bus.payload_byte = out_data.payload_byte;
  assign out_bus.status       = out_data.status;

`ifndef NO_ASSERTIONS
  // Input is held off only while a result is waiting at the output.
  a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_bus.ready |-> out_bus.valid)
    else $error("input stalled with no result pending");

  // Payload results carry no status code.
  a_byte_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && out_bus.kind == KIND_BYTE) |-> out_bus.status == ST_OK)
    else $error("payload byte result with nonzero status");

  // Status results carry a zero payload byte.
  a_status_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && out_bus.kind == KIND_STATUS) |-> out_bus.payload_byte == 8'd0)
    else $error("status result with nonzero payload byte");

  // The checksum low byte always ends the attempt.
  a_ck_lo_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && phase == PH_CK_LO) |=> phase == PH_WAIT_A0)
    else $error("frame did not end after checksum");
`endif

endmodule

`default_nettype wire

>>> tb/tb_binary_frame_receiver.sv
// Self-checking testbench for the binary frame receiver: a random-burst byte
// sender, a stalling result sink, APB register writes and a built-in predictor.
// Depends on bfr_pkg, bfr_in_if, bfr_out_if and binary_frame_receiver.
`timescale 1ns / 100ps

module tb_binary_frame_receiver;
  import bfr_pkg::*;

  localparam int DRAIN_CYCLES = 8;

  // One received byte or timeout, and one result of the deframer.
  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } rx_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    status_t    status;
  } res_item_t;

  // Receiver stall patterns.
  typedef enum int {
    RDY_ALWAYS,
    RDY_TOGGLE,
    RDY_HALF,
    RDY_SPARSE
  } ready_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  bfr_in_if  in_ch ();
  bfr_out_if out_ch ();

  binary_frame_receiver i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_ch),
    .out_bus (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Clock with a 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Bytes waiting to be sent and results the deframer should produce.
  rx_item_t  pending_rx[$];
  res_item_t frame_results[$];
  int        items_queued = 0;
  int        mismatch_count = 0;
  bit        in_taken = 1'b0;

  // Predictor copy of the registers and the deframing state.
  logic [15:0]      cfg_patience = PATIENCE_RESET;
  logic [15:0]      cfg_max_len = MAX_LEN_RESET;
  phase_t           rx_phase;
  logic [15:0]      patience_budget;
  logic [15:0]      frame_len;
  logic [15:0]      payload_count;
  logic [SUM_W-1:0] byte_sum;
  logic [7:0]       held_byte;

  function automatic void start_attempt();
    rx_phase        = PH_WAIT_A0;
    patience_budget = cfg_patience;
    frame_len       = '0;
    payload_count   = '0;
    byte_sum        = '0;
    held_byte       = '0;
  endfunction

  // Spend one unit of patience; true when it has run out.
  function automatic bit burn_patience();
    if (patience_budget <= 16'd1) begin
      patience_budget = '0;
      return 1'b1;
    end
    patience_budget = patience_budget - 16'd1;
    return 1'b0;
  endfunction

  // Advance the predictor by one transfer; returns 1 when a result follows.
  function automatic bit deframe_step(input rx_item_t it, output res_item_t r);
    bit         tmo;
    bit         ended;
    status_t    st;
    logic [7:0] b;
    tmo   = (it.op == OP_TIMEOUT);
    b     = it.rx_byte;
    ended = 1'b0;
    st    = ST_OK;
    r     = '{kind: KIND_BYTE, payload_byte: 8'h00, status: ST_OK};
    deframe_step = 1'b0;
    case (rx_phase)
      PH_WAIT_A0: begin
        if (!tmo && b == SYNC_FIRST) begin
          rx_phase = PH_WAIT_A2;
        end else if (tmo || b != SYNC_SECOND) begin
          if (burn_patience()) begin
            ended = 1'b1;
            st    = ST_NO_SYNC;
          end
        end
      end
      PH_WAIT_A2: begin
        if (!tmo && b == SYNC_SECOND) begin
          rx_phase = PH_LEN_HI;
        end else if (tmo || b != SYNC_FIRST) begin
          if (!tmo) rx_phase = PH_WAIT_A0;
          if (burn_patience()) begin
            ended = 1'b1;
            st    = ST_NO_SYNC;
          end
        end
      end
      PH_LEN_HI: begin
        if (tmo) begin
          ended = 1'b1;
          st    = ST_LEN_MISSING;
        end else begin
          held_byte = b;
          rx_phase  = PH_LEN_LO;
        end
      end
      PH_LEN_LO: begin
        if (tmo) begin
          ended = 1'b1;
          st    = ST_LEN_MISSING;
        end else begin
          frame_len = {held_byte, b};
          if (frame_len == 16'd0 || frame_len > cfg_max_len) begin
            ended = 1'b1;
            st    = ST_BAD_LENGTH;
          end else begin
            payload_count = '0;
            byte_sum      = '0;
            rx_phase      = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        if (tmo) begin
          ended = 1'b1;
          st    = ST_TRUNCATED;
        end else begin
          byte_sum      = byte_sum + SUM_W'(b);
          payload_count = payload_count + 16'd1;
          if (payload_count >= frame_len) rx_phase = PH_CK_HI;
          r.payload_byte = b;
          deframe_step   = 1'b1;
        end
      end
      PH_CK_HI: begin
        if (tmo) begin
          ended = 1'b1;
          st    = ST_TRUNCATED;
        end else begin
          held_byte = b;
          rx_phase  = PH_CK_LO;
        end
      end
      PH_CK_LO: begin
        ended = 1'b1;
        if (tmo) st = ST_TRUNCATED;
        else st = ({held_byte, b} == {1'b0, byte_sum}) ? ST_OK : ST_CHECKSUM;
      end
      default: start_attempt();
    endcase
    // Every status closes the attempt and starts a fresh hunt.
    if (ended) begin
      r.kind       = KIND_STATUS;
      r.status     = st;
      deframe_step = 1'b1;
      start_attempt();
    end
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch at %0t: %s", $realtime, msg);
  endfunction

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (gap_left != 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (pending_rx.size() != 0) begin
        in_ch.valid   <= 1'b1;
        in_ch.op      <= pending_rx[0].op;
        in_ch.rx_byte <= pending_rx[0].rx_byte;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result sink: a random stall pattern, picked anew whenever its hold count runs out.
  ready_mode_t ready_mode = RDY_ALWAYS;
  int          ready_hold = 0;

  always @(negedge clk) begin
    if (ready_hold == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 3));
      ready_hold = $urandom_range(16, 96);
    end
    ready_hold--;
    case (ready_mode)
      RDY_ALWAYS: out_ch.ready <= 1'b1;
      RDY_TOGGLE: out_ch.ready <= ~out_ch.ready;
      RDY_HALF:   out_ch.ready <= 1'($urandom_range(0, 1));
      default:    out_ch.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Monitor: predict on each input transfer, check each result transfer.
  always @(posedge clk) begin : monitor
    rx_item_t  got_in;
    res_item_t pred;
    res_item_t want;
    in_taken = 1'b0;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        in_taken       = 1'b1;
        got_in.op      = in_ch.op;
        got_in.rx_byte = in_ch.rx_byte;
        void'(pending_rx.pop_front());
        if (deframe_step(got_in, pred)) frame_results.insert(frame_results.size(), pred);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (frame_results.size() == 0) begin
          note_mismatch($sformatf("unexpected result kind %0d byte %02h status %0d",
                                  out_ch.kind, out_ch.payload_byte, out_ch.status));
        end else begin
          want = frame_results.pop_front();
          if (out_ch.kind !== want.kind || out_ch.payload_byte !== want.payload_byte ||
              out_ch.status !== want.status) begin
            note_mismatch($sformatf(
              "expected kind %0d byte %02h status %s, got kind %0d byte %02h status %0d",
              want.kind, want.payload_byte, want.status.name(),
              out_ch.kind, out_ch.payload_byte, out_ch.status));
          end
        end
      end
    end
  end

  // Stimulus building blocks.
  function automatic void push_item(input logic op, input logic [7:0] b);
    rx_item_t it;
    it.op      = op;
    it.rx_byte = b;
    pending_rx.insert(pending_rx.size(), it);
    items_queued++;
  endfunction

  function automatic void push_byte(input logic [7:0] b);
    push_item(OP_BYTE, b);
  endfunction

  function automatic void push_timeout();
    push_item(OP_TIMEOUT, 8'($urandom));
  endfunction

  // Push the n lowest bytes of seq, most significant first.
  function automatic void push_bytes(input logic [63:0] seq, input int n);
    for (int i = n - 1; i >= 0; i--) push_byte(seq[8*i +: 8]);
  endfunction

  function automatic void push_sync();
    push_byte(SYNC_FIRST);
    push_byte(SYNC_SECOND);
  endfunction

  function automatic void push_noise();
    case ($urandom_range(0, 5))
      0:       push_timeout();
      1:       push_byte(SYNC_FIRST);
      2:       push_byte(SYNC_SECOND);
      default: push_byte(8'($urandom));
    endcase
  endfunction

  // Mostly well-formed frames with random content, plus broken frames and noise.
  function automatic void add_random_traffic(input int n_items);
    int               start;
    int               pick;
    int               len;
    int               cap;
    int               cut;
    logic [SUM_W-1:0] sum;
    logic [15:0]      ck;
    logic [7:0]       b;
    start = items_queued;
    while (items_queued - start < n_items) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 2) == 0) push_noise();
      if (pick < 65) begin
        cap = (cfg_max_len < 16'd12) ? int'(cfg_max_len) : 12;
        len = $urandom_range(1, cap);
        cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, len + 1) : len + 2;
        sum = '0;
        ck  = '0;
        push_sync();
        push_bytes(64'(len), 2);
        for (int i = 0; i < cut && i < len + 2; i++) begin
          if (i < len) begin
            b   = 8'($urandom);
            sum = sum + SUM_W'(b);
            push_byte(b);
          end else begin
            if (i == len) ck = ($urandom_range(0, 5) == 0) ? 16'($urandom) : {1'b0, sum};
            push_byte((i == len) ? ck[15:8] : ck[7:0]);
          end
        end
        if (cut < len + 2) push_timeout();
      end else if (pick < 75) begin
        if (cfg_max_len == 16'hFFFF || $urandom_range(0, 2) == 0) len = 0;
        else len = $urandom_range(int'(cfg_max_len) + 1, 65535);
        push_sync();
        push_bytes(64'(len), 2);
      end else if (pick < 83) begin
        push_sync();
        if ($urandom_range(0, 1) == 1) push_byte(8'($urandom));
        push_timeout();
      end else begin
        repeat ($urandom_range(1, 4)) push_noise();
      end
    end
  endfunction

  // Wait until every byte is taken and every result has arrived, then wait out the drain margin.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_rx.size() != 0 || frame_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Close any attempt in progress so the next register write finds a fresh hunt.
  task automatic settle();
    wait_drained();
    if (rx_phase != PH_WAIT_A0 || patience_budget != cfg_patience) begin
      if (rx_phase == PH_WAIT_A0 || rx_phase == PH_WAIT_A2) push_sync();
      push_timeout();
      wait_drained();
    end
  endtask

  // APB write followed by a read-back of the same register.
  task automatic reg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [15:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= CFG_DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    if (addr == ADDR_PATIENCE) cfg_patience = value;
    else cfg_max_len = value;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    if (prdata[15:0] !== value)
      note_mismatch($sformatf("register %0h read %04h, wrote %04h", addr, prdata[15:0], value));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // New register values; a sync pair and a timeout then start a fresh attempt
  // so that the new patience limit takes effect.
  task automatic reconfigure(input logic [15:0] patience, input logic [15:0] max_len);
    settle();
    reg_write(ADDR_PATIENCE, patience);
    reg_write(ADDR_MAX_LEN, max_len);
    push_sync();
    push_timeout();
  endtask

  // Main sequence: reset, then directed and random traffic under several settings.
  initial begin
    in_ch.valid   = 1'b0;
    in_ch.op      = OP_BYTE;
    in_ch.rx_byte = 8'h00;
    out_ch.ready  = 1'b0;
    start_attempt();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset values: hunting costs, a good frame, zero length, missing length,
    // truncated payload.
    push_timeout();
    push_byte(SYNC_SECOND);
    push_byte(8'h00);
    push_byte(SYNC_FIRST);
    push_byte(SYNC_FIRST);
    push_byte(8'h55);
    push_sync();
    push_bytes(64'h0001_FF_00FF, 5);
    push_sync();
    push_bytes(64'h0000, 2);
    push_sync();
    push_timeout();
    push_sync();
    push_bytes(64'h0002_12, 3);
    push_timeout();
    add_random_traffic(60);

    // Smallest settings: one stray byte ends the hunt, length 2 is too long,
    // a checksum with its top bit set never matches.
    reconfigure(16'd1, 16'd1);
    push_byte(8'h33);
    push_sync();
    push_bytes(64'h0002, 2);
    push_sync();
    push_bytes(64'h0001_80_8000, 5);
    push_sync();
    push_bytes(64'h0001_00_0000, 5);
    push_sync();
    push_bytes(64'h0001_34, 3);
    push_timeout();
    add_random_traffic(60);

    // Zero patience acts as one; full length range with a truncated huge frame.
    reconfigure(16'd0, 16'hFFFF);
    push_timeout();
    push_sync();
    push_bytes(64'hFFFF_12_34, 4);
    push_timeout();
    push_sync();
    push_bytes(64'h0001_34_00, 4);
    push_timeout();
    push_sync();
    push_byte(8'h07);
    push_timeout();
    add_random_traffic(60);

    // Largest patience with the default length limit.
    reconfigure(16'hFFFF, MAX_LEN_RESET);
    push_sync();
    push_bytes(64'hFFFF, 2);
    add_random_traffic(60);

    // Small patience and a short length limit.
    reconfigure(16'd3, 16'd20);
    add_random_traffic(60);

    wait_drained();
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
